/* rtl/sha1sh_pkg.sv */
package sha1sh_pkg;

	// Source of the byte that is shifted into the block buffer.
	typedef enum logic [1:0] {
		BSEL_DATA = 2'd0,
		BSEL_MARK = 2'd1,
		BSEL_ZERO = 2'd2,
		BSEL_LEN  = 2'd3
	} bsel_t;

	typedef struct packed {
		logic  push;
		bsel_t bsel;
		logic  count;
		logic  round;
		logic  add;
		logic  emit;
	} cmd_t;

	typedef struct packed {
		logic block_full;
		logic at_len;
		logic last_round;
		logic out_busy;
	} sts_t;

	localparam logic [0:4][31:0] H_INIT = {
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] K_0 = 32'h5A827999;
	localparam logic [31:0] K_1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_3 = 32'hCA62C1D6;

	localparam logic [7:0] MARK_BYTE  = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;
	localparam logic [5:0] FILL_LAST  = 6'd63;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [6:0] ROUND_END  = 7'd80;
	localparam logic [6:0] ROUND_W16  = 7'd16;
	localparam logic [6:0] ROUND_20   = 7'd20;
	localparam logic [6:0] ROUND_40   = 7'd40;
	localparam logic [6:0] ROUND_60   = 7'd60;

endpackage

/* rtl/sha1sh_dp.sv */
module sha1sh_dp import sha1sh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	input  logic [7:0]   data_byte,
	input  logic         out_ready,
	output sts_t         sts,
	output logic         out_valid,
	output logic [159:0] out_digest,  // digest_word0 .. digest_word4
	output logic         out_error
);

	// The block buffer and the schedule window share one shift register:
	// word 0 sits in the top bits, bytes enter at the bottom.
	logic [0:15][31:0] window_q;
	logic [511:0]      win_flat;
	logic [0:4][31:0]  work_q;
	logic [0:4][31:0]  hash_q;
	logic [5:0]        fill_q;
	logic [63:0]       bitlen_q;
	logic              ovf_q;
	logic [6:0]        round_q;
	logic              out_valid_q;
	logic [159:0]      out_digest_q;
	logic              out_error_q;

	logic [7:0]  push_byte;
	logic [7:0]  len_byte;
	logic [31:0] w_mix;
	logic [31:0] w_cur;
	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] t_val;
	logic [31:0] a_w, b_w, c_w, d_w, e_w;

	assign win_flat = window_q;
	assign a_w = work_q[0];
	assign b_w = work_q[1];
	assign c_w = work_q[2];
	assign d_w = work_q[3];
	assign e_w = work_q[4];

	// Length bytes go out most significant first; offset 56 + k carries byte 7 - k.
	assign len_byte = 8'(bitlen_q >> {~fill_q[2:0], 3'b000});

	always_comb begin
		unique case (cmd.bsel)
			BSEL_DATA: push_byte = data_byte;
			BSEL_MARK: push_byte = MARK_BYTE;
			BSEL_ZERO: push_byte = 8'h00;
			BSEL_LEN:  push_byte = len_byte;
			default:   push_byte = 8'h00;
		endcase
	end

	assign w_mix = window_q[13] ^ window_q[8] ^ window_q[2] ^ window_q[0];
	assign w_cur = (round_q < ROUND_W16) ? window_q[0] : {w_mix[30:0], w_mix[31]};

	always_comb begin
		if (round_q < ROUND_20) begin
			f_val = (b_w & c_w) | (~b_w & d_w);
			k_val = K_0;
		end else if (round_q < ROUND_40) begin
			f_val = b_w ^ c_w ^ d_w;
			k_val = K_1;
		end else if (round_q < ROUND_60) begin
			f_val = (b_w & c_w) | (b_w & d_w) | (c_w & d_w);
			k_val = K_2;
		end else begin
			f_val = b_w ^ c_w ^ d_w;
			k_val = K_3;
		end
	end

	assign t_val = {a_w[26:0], a_w[31:27]} + f_val + e_w + k_val + w_cur;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			window_q <= {win_flat[503:0], push_byte};
			if (fill_q == FILL_LAST) begin
				work_q <= hash_q;
			end
		end else if (cmd.round) begin
			window_q <= {win_flat[479:0], w_cur};
			work_q   <= {t_val, a_w, {b_w[1:0], b_w[31:2]}, c_w, d_w};
		end
		if (cmd.emit) begin
			out_digest_q <= {hash_q[4], hash_q[3], hash_q[2], hash_q[1], hash_q[0]};
			out_error_q  <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q      <= H_INIT;
			fill_q      <= '0;
			bitlen_q    <= '0;
			ovf_q       <= 1'b0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				fill_q <= fill_q + 6'd1;
				if (fill_q == FILL_LAST) begin
					round_q <= '0;
				end
			end else if (cmd.round) begin
				round_q <= round_q + 7'd1;
			end
			if (cmd.count) begin
				if (&bitlen_q[63:3]) begin
					ovf_q <= 1'b1;
				end
				bitlen_q <= bitlen_q + 64'd8;
			end
			if (cmd.add) begin
				for (int i = 0; i < 5; i++) begin
					hash_q[i] <= hash_q[i] + work_q[i];
				end
			end
			if (cmd.emit) begin
				hash_q      <= H_INIT;
				bitlen_q    <= '0;
				ovf_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.block_full = (fill_q == FILL_LAST);
	assign sts.at_len     = (fill_q == LEN_OFFSET);
	assign sts.last_round = (round_q == LAST_ROUND);
	assign sts.out_busy   = out_valid_q & ~out_ready;

	assign out_valid  = out_valid_q;
	assign out_digest = out_digest_q;
	assign out_error  = out_error_q;

	a_round_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round |-> round_q < ROUND_END)
		else $error("round issued past the last round");

	a_emit_on_block_edge: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> fill_q == '0)
		else $error("digest emitted with a partly filled block");

	a_emit_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q && bitlen_q == '0 && !ovf_q)
		else $error("emit did not restart the message state");

endmodule

/* rtl/sha1sh_ctrl.sv */
module sha1sh_ctrl import sha1sh_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic byte_present,
	input  logic end_of_message,
	input  sts_t sts,
	output logic in_ready,
	output cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MARK = 7'b0000010,
		S_ZERO = 7'b0000100,
		S_LEN  = 7'b0001000,
		S_COMP = 7'b0010000,
		S_ADD  = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	state_t ret_q, ret_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (byte_present) begin
						cmd.push  = 1'b1;
						cmd.bsel  = BSEL_DATA;
						cmd.count = 1'b1;
					end
					if (byte_present && sts.block_full) begin
						state_d = S_COMP;
						ret_d   = end_of_message ? S_MARK : S_IDLE;
					end else if (end_of_message) begin
						state_d = S_MARK;
					end
				end
			end
			S_MARK: begin
				cmd.push = 1'b1;
				cmd.bsel = BSEL_MARK;
				if (sts.block_full) begin
					state_d = S_COMP;
					ret_d   = S_ZERO;
				end else begin
					state_d = S_ZERO;
				end
			end
			S_ZERO: begin
				if (sts.at_len) begin
					state_d = S_LEN;
				end else begin
					cmd.push = 1'b1;
					cmd.bsel = BSEL_ZERO;
					if (sts.block_full) begin
						state_d = S_COMP;
						ret_d   = S_ZERO;
					end
				end
			end
			S_LEN: begin
				cmd.push = 1'b1;
				cmd.bsel = BSEL_LEN;
				if (sts.block_full) begin
					state_d = S_COMP;
					ret_d   = S_FIN;
				end
			end
			S_COMP: begin
				cmd.round = 1'b1;
				if (sts.last_round) begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = ret_q;
			end
			S_FIN: begin
				// Hold the digest back until the output register is free.
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	a_full_block_compresses: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && sts.block_full) |=> state_q == S_COMP)
		else $error("full block not followed by compression");

	a_add_after_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ADD |-> $past(state_q) == S_COMP)
		else $error("chaining add without preceding rounds");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state is not one-hot");

endmodule

/* rtl/sha1_stream_hasher_core.sv */
// Input: a word without end of message is taken while the core is idle; the word that fills
// a 64-byte block is followed by an input stall for 80 rounds and one chaining add.
// Throughput: one byte per cycle while the core is idle, with no compression or padding.
// End of message: the mark byte, zero bytes up to offset 56 and the length bytes are pushed,
// each full block is compressed, and the digest is emitted once the output register is free.
// Reset (arst_n low) clears control and loads the initial chaining words; no clearing pass.
module sha1_stream_hasher_core import sha1sh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic [0:0]   s_tuser,   // [0] byte_present
	input  logic         s_tlast,   // end_of_message
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [159:0] m_tdata,   // digest_word0 .. digest_word4, 32 bits each
	output logic [0:0]   m_tuser    // [0] length_error
);

	cmd_t cmd;
	sts_t sts;

	sha1sh_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.byte_present   (s_tuser[0]),
		.end_of_message (s_tlast),
		.sts            (sts),
		.in_ready       (s_tready),
		.cmd            (cmd)
	);

	sha1sh_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.data_byte  (s_tdata),
		.out_ready  (m_tready),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.out_digest (m_tdata),
		.out_error  (m_tuser[0])
	);

endmodule

/* tb/sv/sha1_digest_checker.sv */
`timescale 1ns / 1ps

module sha1_digest_checker import sha1sh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic [0:0]   s_tuser,   // [0] byte_present
	input  logic         s_tlast,   // end_of_message
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [159:0] m_tdata,   // digest_word0 .. digest_word4, 32 bits each
	input  logic [0:0]   m_tuser,   // [0] length_error
	output int           pending,
	output int           failures
);

	typedef struct packed {
		logic             length_error;
		logic [4:0][31:0] words;
	} digest_t;

	digest_t          digest_q[$];
	logic [4:0][31:0] hash_words;
	logic [63:0][7:0] block_bytes;
	logic [5:0]       fill_pos;
	logic [63:0]      msg_bits;
	logic             bits_wrapped;

	function automatic logic [4:0][31:0] sha1_compress(input logic [4:0][31:0] cv,
			input logic [63:0][7:0] blk);
		logic [15:0][31:0] w;
		logic [31:0]       a, b, c, d, e, f, k, t, x;
		logic [4:0][31:0]  nxt;
		int                r;
		for (r = 0; r < 16; r++)
			w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
		a = cv[0];
		b = cv[1];
		c = cv[2];
		d = cv[3];
		e = cv[4];
		for (r = 0; r < 80; r++) begin
			// The schedule is kept in a sliding window of sixteen words.
			if (r >= 16) begin
				x = w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15];
				w[r & 15] = {x[30:0], x[31]};
			end
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K_0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_2;
			end else begin
				f = b ^ c ^ d;
				k = K_3;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[r & 15];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		nxt[0] = cv[0] + a;
		nxt[1] = cv[1] + b;
		nxt[2] = cv[2] + c;
		nxt[3] = cv[3] + d;
		nxt[4] = cv[4] + e;
		return nxt;
	endfunction

	task automatic absorb_byte(input logic [7:0] b);
		block_bytes[fill_pos] = b;
		fill_pos = fill_pos + 6'd1;
		if (fill_pos == 6'd0)
			hash_words = sha1_compress(hash_words, block_bytes);
	endtask

	task automatic restart_message();
		int i;
		for (i = 0; i < 5; i++)
			hash_words[i] = H_INIT[i];
		fill_pos = '0;
		msg_bits = '0;
		bits_wrapped = 1'b0;
	endtask

	task automatic take_word(input logic [7:0] b, input logic present, input logic last);
		digest_t d;
		int      i;
		if (present) begin
			absorb_byte(b);
			if (msg_bits > 64'hFFFF_FFFF_FFFF_FFF7)
				bits_wrapped = 1'b1;
			msg_bits = msg_bits + 64'd8;
		end
		if (last) begin
			absorb_byte(MARK_BYTE);
			while (fill_pos != LEN_OFFSET)
				absorb_byte(8'h00);
			for (i = 7; i >= 0; i--)
				absorb_byte(msg_bits[8*i +: 8]);
			d.words = hash_words;
			d.length_error = bits_wrapped;
			digest_q.push_back(d);
			restart_message();
		end
	endtask

	task automatic note_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (failures < 10)
			$display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
		failures++;
	endtask

	// The result side is checked before the input side, since a word taken at
	// this edge cannot yet have its digest on the output.
	always @(posedge clk or negedge arst_n) begin
		digest_t want;
		int      i;
		if (!arst_n) begin
			restart_message();
			digest_q.delete();
			failures = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (digest_q.size() == 0) begin
					if (failures < 10)
						$display("%0t: digest %h arrived with none outstanding", $time, m_tdata);
					failures++;
				end else begin
					want = digest_q.pop_front();
					for (i = 0; i < 5; i++)
						if (m_tdata[32*i +: 32] !== want.words[i])
							note_mismatch($sformatf("digest_word%0d", i), want.words[i],
								m_tdata[32*i +: 32]);
					// A wrapped bit count would take 2^61 bytes, so this flag is only
					// ever seen clear in a run of sane length.
					if (m_tuser[0] !== want.length_error)
						note_mismatch("length_error", 32'(want.length_error), 32'(m_tuser[0]));
				end
			end
			if (s_tvalid && s_tready)
				take_word(s_tdata, s_tuser[0], s_tlast);
			pending <= digest_q.size();
		end
	end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	localparam int ITEM_TARGET  = 1950;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int DRAIN_CYCLES = 200;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_BURSTY
	} rx_mode_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic [0:0]   s_tuser;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [159:0] m_tdata;
	logic [0:0]   m_tuser;

	int       pending;
	int       failures;
	int       cycle_count;
	int       sent_items;
	int       burst_left;
	rx_mode_t rx_mode = RX_OPEN;
	logic [7:0] rx_phase = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sha1_stream_hasher_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	sha1_digest_checker u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.pending  (pending),
		.failures (failures)
	);

	// The receiver changes its mood whenever its 8-bit phase counter wraps, from always ready to
	// long stretches of stall.
	always @(posedge clk) begin
		rx_phase <= rx_phase + 8'd1;
		if (rx_phase == 8'd0)
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
			default:   m_tready <= (rx_phase[5:0] < 6'd4);
		endcase
	end

	// Offers one word and returns at the edge that takes it; a gap of random
	// length falls between bursts.
	task automatic send_word(input logic [7:0] data, input logic present, input logic last);
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 4);
				6, 7, 8:          gap = $urandom_range(5, 24);
				default:          gap = $urandom_range(40, 160);
			endcase
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 48);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= present;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	task automatic drain_digests();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic send_message(input int len, input logic end_on_byte);
		int i;
		for (i = 0; i < len; i++) begin
			// Now and then a word with no byte and no end, which must change nothing.
			if ($urandom_range(0, 15) == 0) begin
				send_word(8'($urandom), 1'b0, 1'b0);
				sent_items++;
			end
			send_word(8'($urandom), 1'b1, end_on_byte && i == len - 1);
			sent_items++;
		end
		if (!end_on_byte || len == 0) begin
			send_word(8'($urandom), 1'b0, 1'b1);
			sent_items++;
		end
	endtask

	// Mostly short messages, some near the padding boundaries and a few long.
	function automatic int pick_length();
		int boundary[9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return $urandom_range(0, 63);
		else if (r < 16)
			return $urandom_range(64, 130);
		else if (r < 19)
			return boundary[$urandom_range(0, 8)];
		else
			return $urandom_range(131, 260);
	endfunction

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench failed");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		s_tlast <= 1'b0;
		sent_items = 0;
		burst_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message: an end word with no byte, its data to be ignored.
		send_word(8'hA5, 1'b0, 1'b1);
		// "abc", the last byte arriving together with the end.
		send_word(8'h61, 1'b1, 1'b0);
		send_word(8'h62, 1'b1, 1'b0);
		send_word(8'h63, 1'b1, 1'b1);
		// Extreme byte values, an ignored word, and a separate end word.
		send_word(8'hFF, 1'b0, 1'b0);
		send_word(8'h00, 1'b1, 1'b0);
		send_word(8'hFF, 1'b1, 1'b0);
		send_word(8'h80, 1'b1, 1'b0);
		send_word(8'h00, 1'b0, 1'b1);
		send_word(8'hFF, 1'b1, 1'b0);
		send_word(8'h00, 1'b1, 1'b1);
		sent_items = 11;
		drain_digests();

		while (sent_items < ITEM_TARGET) begin
			send_message(pick_length(), 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 9) == 0)
				drain_digests();
		end

		drain_digests();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
